@@ rtl/core/tgarle_pkg.sv @@
// Shared types and constants for the TGA run-length row decoder.
// Used by tgarle_palette and tga_rle_row_decoder_core; depends on nothing.
package tgarle_pkg;

  localparam int PaletteBytesDef = 1024;
  localparam int PalIndexW = 10;
  localparam int PalBaseW = 11;
  localparam int RowWidthW = 16;
  localparam int RunLenW = 8;

  typedef enum logic [1:0] {
    CfgCompressed = 2'd0,
    CfgPixelFormat = 2'd1,
    CfgColorEntryBytes = 2'd2,
    CfgRowWidth = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FmtPal = 2'd0,
    Fmt16 = 2'd1,
    Fmt24 = 2'd2,
    Fmt32 = 2'd3
  } pix_fmt_e;

  typedef enum logic {
    PhHeader = 1'b0,
    PhData = 1'b1
  } phase_e;

  typedef struct packed {
    logic en;
    logic [PalIndexW-1:0] index;
    logic [7:0] value;
  } pal_wr_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pal_rgb_t;

endpackage

@@ rtl/core/tga_rle_row_decoder_core.sv @@
// The block takes one word per clock (a row stream byte or a palette byte
// write) and gives at most one pixel result for the word that completes the
// pixel; throughput is one word per cycle whenever results are taken. The
// result passes the pending result register, loaded together with the
// registered palette read in four byte banks, and then the output register.
// The palette needs no initialization pass after reset, but an entry must be
// written before a pixel reads it.
// Top level of the TGA run-length row decoder. Depends on tgarle_pkg and
// tgarle_palette.
module tga_rle_row_decoder_core #(
  parameter int PaletteBytes = tgarle_pkg::PaletteBytesDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [tgarle_pkg::RowWidthW-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  func_i,
  input  logic [7:0]                            data_byte_i,
  input  logic [tgarle_pkg::PalIndexW-1:0]      palette_index_i,
  input  logic [7:0]                            palette_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [31:0]                           pixel_word_o,
  output logic [tgarle_pkg::RunLenW-1:0]        run_length_o,
  output logic                                  last_in_row_o
);

  localparam int Cw = tgarle_pkg::RowWidthW;
  localparam int Nw = tgarle_pkg::RunLenW;

  logic compressed_q;
  tgarle_pkg::pix_fmt_e fmt_q;
  logic [2:0] ceb_q;
  logic [Cw-1:0] row_width_q;

  tgarle_pkg::phase_e phase_q, phase_d;
  logic run_q, run_d;
  logic [Nw-1:0] left_q, left_d;
  logic [1:0] bip_q, bip_d;
  logic [31:0] gather_q, gather_d;
  logic [Cw-1:0] column_q, column_d;
  logic drop_q, drop_d;

  logic in_acc, stream_acc;
  logic emit;
  logic [Nw-1:0] emit_n;
  logic emit_last;

  logic a_valid_q, a_valid_d;
  logic a_adv, a_load;
  logic [31:0] a_gather_q;
  logic [Nw-1:0] a_n_q;
  logic a_last_q;
  tgarle_pkg::pix_fmt_e a_fmt_q;

  logic out_valid_q, out_valid_d, out_load;
  logic [31:0] pixel_q, pixel_d;
  logic [Nw-1:0] run_len_q;
  logic last_q;

  tgarle_pkg::pal_wr_t pal_wr;
  tgarle_pkg::pal_rgb_t pal_rgb;
  logic [tgarle_pkg::PalBaseW-1:0] pal_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compressed_q <= 1'b0;
      fmt_q <= tgarle_pkg::Fmt32;
      ceb_q <= 3'd3;
      row_width_q <= Cw'(1);
    end else if (cfg_we_i) begin
      unique case (tgarle_pkg::cfg_reg_e'(cfg_idx_i))
        tgarle_pkg::CfgCompressed: compressed_q <= cfg_data_i[0];
        tgarle_pkg::CfgPixelFormat: fmt_q <= tgarle_pkg::pix_fmt_e'(cfg_data_i[1:0]);
        tgarle_pkg::CfgColorEntryBytes: ceb_q <= cfg_data_i[2:0];
        default: row_width_q <= cfg_data_i;
      endcase
    end
  end

  assign a_adv = !out_valid_q || out_ready_i;
  assign in_acc = in_valid_i && in_ready_o;
  assign stream_acc = in_acc && !func_i;
  assign a_load = stream_acc && emit;
  assign out_load = a_valid_q && a_adv;

  // Stream parser: packet headers, pixel gathering, clipping at the row end.
  always_comb begin
    logic [Cw-1:0] w, rem;
    logic [31:0] g;
    logic [Nw-1:0] n, left_dec;
    logic [Cw-1:0] n_wide;

    phase_d = phase_q;
    run_d = run_q;
    left_d = left_q;
    bip_d = bip_q;
    gather_d = gather_q;
    column_d = column_q;
    drop_d = drop_q;
    emit = 1'b0;
    emit_n = Nw'(1);
    emit_last = 1'b0;

    w = (row_width_q == '0) ? Cw'(1) : row_width_q;
    rem = (column_q < w) ? (w - column_q) : Cw'(1);
    g = ((bip_q == 2'd0) ? 32'h0 : gather_q) | (32'(data_byte_i) << {bip_q, 3'b000});
    left_dec = (left_q != '0) ? (left_q - Nw'(1)) : '0;
    n_wide = ({{(Cw-Nw){1'b0}}, left_q} < rem) ? {{(Cw-Nw){1'b0}}, left_q} : rem;
    n = (n_wide[Nw-1:0] == '0) ? Nw'(1) : n_wide[Nw-1:0];

    if (stream_acc) begin
      if (compressed_q && phase_q == tgarle_pkg::PhHeader) begin
        run_d = data_byte_i[7];
        left_d = {1'b0, data_byte_i[6:0]} + Nw'(1);
        phase_d = tgarle_pkg::PhData;
        bip_d = 2'd0;
        gather_d = 32'h0;
        drop_d = 1'b0;
      end else if (bip_q < 2'(fmt_q)) begin
        bip_d = bip_q + 2'd1;
        gather_d = g;
      end else begin
        bip_d = 2'd0;
        gather_d = g;
        if (!compressed_q) begin
          emit = 1'b1;
        end else if (run_q) begin
          phase_d = tgarle_pkg::PhHeader;
          left_d = '0;
          emit = 1'b1;
          emit_n = n;
        end else begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = tgarle_pkg::PhHeader;
          end
          if (drop_q) begin
            if (left_dec == '0) begin
              drop_d = 1'b0;
            end
          end else begin
            emit = 1'b1;
          end
        end
      end
    end

    if (emit) begin
      emit_last = {{(Cw-Nw){1'b0}}, emit_n} >= rem;
      column_d = emit_last ? '0 : (column_q + {{(Cw-Nw){1'b0}}, emit_n});
      if (emit_last && compressed_q && !run_q && left_dec != '0) begin
        drop_d = 1'b1;
      end
    end
  end

  always_comb begin
    in_ready_o = !a_valid_q || a_adv;
    a_valid_d = a_load ? 1'b1 : (a_adv ? 1'b0 : a_valid_q);
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tgarle_pkg::PhHeader;
      run_q <= 1'b0;
      left_q <= '0;
      bip_q <= 2'd0;
      gather_q <= 32'h0;
      column_q <= '0;
      drop_q <= 1'b0;
      a_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      run_q <= run_d;
      left_q <= left_d;
      bip_q <= bip_d;
      gather_q <= gather_d;
      column_q <= column_d;
      drop_q <= drop_d;
      a_valid_q <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_gather_q <= gather_d;
      a_n_q <= emit_n;
      a_last_q <= emit_last;
      a_fmt_q <= fmt_q;
    end
    if (out_load) begin
      pixel_q <= pixel_d;
      run_len_q <= a_n_q;
      last_q <= a_last_q;
    end
  end

  assign pal_base = tgarle_pkg::PalBaseW'(gather_d[7:0]) * tgarle_pkg::PalBaseW'(ceb_q);
  assign pal_wr.en = in_acc && func_i;
  assign pal_wr.index = palette_index_i;
  assign pal_wr.value = palette_value_i;

  tgarle_palette #(
    .PaletteBytes(PaletteBytes)
  ) u_palette (
    .clk_i    (clk_i),
    .wr_i     (pal_wr),
    .rd_en_i  (a_load),
    .rd_base_i(pal_base),
    .rgb_o    (pal_rgb)
  );

  always_comb begin
    logic [7:0] b0, b1;
    b0 = a_gather_q[7:0];
    b1 = a_gather_q[15:8];
    unique case (a_fmt_q)
      tgarle_pkg::Fmt32: pixel_d = {a_gather_q[23:16], a_gather_q[15:8], b0, a_gather_q[31:24]};
      tgarle_pkg::Fmt24: pixel_d = {a_gather_q[23:16], a_gather_q[15:8], b0, 8'h00};
      tgarle_pkg::Fmt16: pixel_d = {b1[6:2], 3'b000, b1[1:0], b0[7:5], 3'b000,
                                    b0[4:0], 3'b000, 8'h00};
      default: pixel_d = {pal_rgb.red, pal_rgb.green, pal_rgb.blue, 8'h00};
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign pixel_word_o = pixel_q;
  assign run_length_o = run_len_q;
  assign last_in_row_o = last_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_adv |=> a_valid_q && $stable(a_n_q) && $stable(a_last_q))
    else $error("pending result lost or changed while stalled");

  run_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> run_length_o != '0 && run_length_o <= Nw'(128))
    else $error("run length out of range");

  drop_raw_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> !run_q)
    else $error("dropping set outside a raw packet");

  row_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_load && emit_last |=> column_q == '0)
    else $error("column not cleared at row end");

endmodule

@@ rtl/core/tgarle_palette.sv @@
// Palette byte store split into four banks by the low address bits, so that
// three consecutive bytes are read together. Depends on tgarle_pkg.
module tgarle_palette #(
  parameter int PaletteBytes = tgarle_pkg::PaletteBytesDef
) (
  input  logic                                clk_i,
  input  tgarle_pkg::pal_wr_t                 wr_i,
  input  logic                                rd_en_i,
  input  logic [tgarle_pkg::PalBaseW-1:0]     rd_base_i,
  output tgarle_pkg::pal_rgb_t                rgb_o
);

  localparam int BankDepth = (PaletteBytes + 3) / 4;
  localparam int RowW = $clog2(BankDepth);
  localparam int AddrW = tgarle_pkg::PalBaseW + 1;
  localparam logic [AddrW-1:0] PalLimit = AddrW'(PaletteBytes);

  logic [1:0] sel_q;
  logic [2:0] inrange_q;
  logic [2:0] inrange_d;
  logic [7:0] bank_q [4];
  logic wr_ok;

  assign wr_ok = wr_i.en && ({2'b00, wr_i.index} < PalLimit);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      inrange_d[j] = ({1'b0, rd_base_i} + AddrW'(j)) < PalLimit;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0] mem [BankDepth];
    logic [1:0] off;
    logic [AddrW-1:0] addr;

    assign off = 2'(k) - rd_base_i[1:0];
    assign addr = {1'b0, rd_base_i} + {{(AddrW-2){1'b0}}, off};

    always_ff @(posedge clk_i) begin
      if (wr_ok && wr_i.index[1:0] == 2'(k)) begin
        mem[wr_i.index[2 +: RowW]] <= wr_i.value;
      end
      if (rd_en_i) begin
        bank_q[k] <= mem[addr[2 +: RowW]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sel_q <= rd_base_i[1:0];
      inrange_q <= inrange_d;
    end
  end

  always_comb begin
    logic [7:0] c0, c1, c2;
    unique case (sel_q)
      2'd0: begin
        c0 = bank_q[0]; c1 = bank_q[1]; c2 = bank_q[2];
      end
      2'd1: begin
        c0 = bank_q[1]; c1 = bank_q[2]; c2 = bank_q[3];
      end
      2'd2: begin
        c0 = bank_q[2]; c1 = bank_q[3]; c2 = bank_q[0];
      end
      default: begin
        c0 = bank_q[3]; c1 = bank_q[0]; c2 = bank_q[1];
      end
    endcase
    rgb_o.blue = inrange_q[0] ? c0 : 8'h00;
    rgb_o.green = inrange_q[1] ? c1 : 8'h00;
    rgb_o.red = inrange_q[2] ? c2 : 8'h00;
  end

endmodule
